// ===== rtl/lodd_pkg.sv =====
package lodd_pkg;

   localparam int unsigned MaxLocksDefault = 16;
   localparam int unsigned AddrWidth       = 48;
   localparam int unsigned TidWidth        = 48;

   localparam logic OpLock   = 1'b0;
   localparam logic OpUnlock = 1'b1;

   localparam logic StatusCycle = 1'b0;
   localparam logic StatusFull  = 1'b1;

   // Search colors.
   localparam logic [1:0] ColorWhite = 2'd0;
   localparam logic [1:0] ColorGrey  = 2'd1;
   localparam logic [1:0] ColorBlack = 2'd2;

   // One result item handed from the state machine to the output register.
   typedef struct packed {
      logic                 valid;
      logic [AddrWidth-1:0] address;
      logic [TidWidth-1:0]  owner;
      logic                 first;
      logic                 status;
      logic                 last;
   } result_type;

endpackage

// ===== rtl/lodd_table.sv =====
// Slot table: lock address and owner per slot, each in a synchronous memory
// with a registered read. One write port and one read port per memory.
module lodd_table #(
   parameter int unsigned MAX_LOCKS = lodd_pkg::MaxLocksDefault,
   localparam int unsigned IdxW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1
) (
   input  logic                           clock,
   input  logic                           addr_we,
   input  logic [IdxW-1:0]                addr_waddr,
   input  logic [lodd_pkg::AddrWidth-1:0] addr_wdata,
   input  logic [IdxW-1:0]                addr_raddr,
   output logic [lodd_pkg::AddrWidth-1:0] addr_rdata,
   input  logic                           own_we,
   input  logic [IdxW-1:0]                own_waddr,
   input  logic [lodd_pkg::TidWidth-1:0]  own_wdata,
   input  logic [IdxW-1:0]                own_raddr,
   output logic [lodd_pkg::TidWidth-1:0]  own_rdata
);

   logic [lodd_pkg::AddrWidth-1:0] addr_mem [MAX_LOCKS];
   logic [lodd_pkg::TidWidth-1:0]  own_mem  [MAX_LOCKS];

   always_ff @(posedge clock) begin
      if (addr_we) begin
         addr_mem[addr_waddr] <= addr_wdata;
      end
      addr_rdata <= addr_mem[addr_raddr];
   end

   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[own_waddr] <= own_wdata;
      end
      own_rdata <= own_mem[own_raddr];
   end

endmodule

// ===== rtl/lock_order_deadlock_detector.sv =====
// Lock-order deadlock detector. An item (operation, thread_id, lock_address)
// is taken when start is high and busy is low. Busy then stays high while the
// item is worked on. The final result of the item is on the rsp_ ports in the
// first cycle with busy low, so the next item may be taken at the same edge
// that takes that result. Results appear on the rsp_ ports with rsp_valid high
// for exactly one cycle each. The receiver cannot stall them, so it must take
// every strobed result. All timing depends on the number of used slots, which
// is at most MAX_LOCKS. The lookup reads the address and owner memories of
// each used slot in turn, issuing the read in S_LOOK and comparing in
// S_LOOK_CHK. A lock item then reads the owner of each used slot while
// adding edges, and sets up the search. The depth-first search takes one
// step per cycle: it tries one edge, tries a start slot or retires a
// finished slot. A cycle report reads the address and owner memories for
// each member before it is strobed out. An unlock runs the lookup and then
// clears the row and column of edges of its slot. A lock of a new address on
// a full table gives one table-full result. After reset the owner memory is
// cleared in a pass over all MAX_LOCKS slots during which busy is high.
module lock_order_deadlock_detector #(
   parameter int unsigned MAX_LOCKS = lodd_pkg::MaxLocksDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_operation,
   input  logic [lodd_pkg::TidWidth-1:0]  req_thread_id,
   input  logic [lodd_pkg::AddrWidth-1:0] req_lock_address,
   output logic                           rsp_valid,
   output logic [lodd_pkg::AddrWidth-1:0] rsp_lock_address_out,
   output logic [lodd_pkg::TidWidth-1:0]  rsp_owner_thread,
   output logic                           rsp_thread_first,
   output logic                           rsp_status,
   output logic                           rsp_last
);

   localparam int unsigned IdxW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
   localparam int unsigned CntW = $clog2(MAX_LOCKS + 1);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_LOOK, S_LOOK_CHK, S_LOCK_OWN, S_LOCK_OWN_CHK,
      S_EDGE, S_EDGE_CHK, S_SRCH_INIT, S_SRCH, S_REP, S_REP_OUT, S_UNLOCK
   } state_type;

   state_type state_ff, state_in;

   // Request registers.
   logic                           op_ff, op_in;
   logic [lodd_pkg::TidWidth-1:0]  tid_ff, tid_in;
   logic [lodd_pkg::AddrWidth-1:0] adr_ff, adr_in;

   logic [CntW-1:0] used_ff, used_in;
   logic [CntW-1:0] cnt_ff, cnt_in;     // Sweep counter.
   logic [IdxW-1:0] idx_ff, idx_in;     // Slot of the current item.

   // Edge matrix, colors, cursors and path stack are small registered arrays.
   logic [MAX_LOCKS-1:0] edges_ff [MAX_LOCKS];
   logic [MAX_LOCKS-1:0] edges_in [MAX_LOCKS];
   logic [1:0]           color_ff [MAX_LOCKS];
   logic [1:0]           color_in [MAX_LOCKS];
   logic [CntW-1:0]      cur_ff   [MAX_LOCKS];
   logic [CntW-1:0]      cur_in   [MAX_LOCKS];
   logic [IdxW-1:0]      stack_ff [MAX_LOCKS];
   logic [IdxW-1:0]      stack_in [MAX_LOCKS];
   logic [CntW-1:0]      depth_ff, depth_in;
   logic [CntW-1:0]      root_ff, root_in;
   logic [IdxW-1:0]      peak_ff, peak_in;

   // Owners already reported in this run, for the first-appearance flag.
   logic [lodd_pkg::TidWidth-1:0] seen_ff [MAX_LOCKS];
   logic [lodd_pkg::TidWidth-1:0] seen_in [MAX_LOCKS];
   logic [CntW-1:0]               nseen_ff, nseen_in;
   logic [IdxW-1:0]               repn_ff, repn_in;

   lodd_pkg::result_type res_ff, res_in;

   // Table memory ports.
   logic                           addr_we, own_we;
   logic [IdxW-1:0]                addr_waddr, own_waddr, addr_raddr, own_raddr;
   logic [lodd_pkg::AddrWidth-1:0] addr_wdata, addr_rdata;
   logic [lodd_pkg::TidWidth-1:0]  own_wdata, own_rdata;

   lodd_table #(.MAX_LOCKS(MAX_LOCKS)) u_table (
      .clock      (clock),
      .addr_we    (addr_we),
      .addr_waddr (addr_waddr),
      .addr_wdata (addr_wdata),
      .addr_raddr (addr_raddr),
      .addr_rdata (addr_rdata),
      .own_we     (own_we),
      .own_waddr  (own_waddr),
      .own_wdata  (own_wdata),
      .own_raddr  (own_raddr),
      .own_rdata  (own_rdata)
   );

   logic [IdxW-1:0] cnt_idx, prev_idx, top_n, cur_j;
   logic            first_c;

   assign cnt_idx  = cnt_ff[IdxW-1:0];
   assign prev_idx = IdxW'(cnt_ff - CntW'(1));
   assign top_n    = stack_ff[IdxW'(depth_ff - CntW'(1))];
   assign cur_j    = cur_ff[top_n][IdxW-1:0];

   always_comb begin
      first_c = 1'b1;
      for (int p = 0; p < MAX_LOCKS; p++) begin
         if (CntW'(p) < nseen_ff && seen_ff[p] == own_rdata) begin
            first_c = 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      tid_in   = tid_ff;
      adr_in   = adr_ff;
      used_in  = used_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      edges_in = edges_ff;
      color_in = color_ff;
      cur_in   = cur_ff;
      stack_in = stack_ff;
      depth_in = depth_ff;
      root_in  = root_ff;
      peak_in  = peak_ff;
      seen_in  = seen_ff;
      nseen_in = nseen_ff;
      repn_in  = repn_ff;
      res_in   = '0;
      res_in.address = adr_ff;
      res_in.owner   = own_rdata;
      addr_we    = 1'b0;
      addr_waddr = idx_ff;
      addr_wdata = adr_ff;
      addr_raddr = cnt_idx;
      own_we     = 1'b0;
      own_waddr  = idx_ff;
      own_wdata  = tid_ff;
      own_raddr  = cnt_idx;

      case (state_ff)
         S_CLEAR: begin
            own_we    = 1'b1;
            own_waddr = cnt_idx;
            own_wdata = '0;
            cnt_in    = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(MAX_LOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               tid_in   = req_thread_id;
               adr_in   = req_lock_address;
               cnt_in   = '0;
               state_in = S_LOOK;
            end
         end
         // Issue a read of slot cnt; compare it the next cycle.
         S_LOOK: begin
            if (cnt_ff >= used_ff) begin
               if (op_ff == lodd_pkg::OpUnlock) begin
                  state_in = S_IDLE;
               end else if (used_ff >= CntW'(MAX_LOCKS)) begin
                  res_in.valid  = 1'b1;
                  res_in.owner  = '0;
                  res_in.status = lodd_pkg::StatusFull;
                  res_in.last   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  idx_in     = used_ff[IdxW-1:0];
                  used_in    = used_ff + CntW'(1);
                  addr_we    = 1'b1;
                  addr_waddr = used_ff[IdxW-1:0];
                  own_we     = 1'b1;
                  own_waddr  = used_ff[IdxW-1:0];
                  own_wdata  = tid_ff;
                  cnt_in     = '0;
                  state_in   = S_EDGE;
               end
            end else begin
               addr_raddr = cnt_idx;
               own_raddr  = cnt_idx;
               cnt_in     = cnt_ff + CntW'(1);
               state_in   = S_LOOK_CHK;
            end
         end
         S_LOOK_CHK: begin
            if (addr_rdata == adr_ff) begin
               idx_in = prev_idx;
               if (op_ff == lodd_pkg::OpUnlock) begin
                  own_we    = 1'b1;
                  own_waddr = prev_idx;
                  own_wdata = '0;
                  state_in  = S_UNLOCK;
               end else begin
                  if (own_rdata == '0) begin
                     own_we    = 1'b1;
                     own_waddr = prev_idx;
                     own_wdata = tid_ff;
                  end
                  cnt_in   = '0;
                  state_in = S_EDGE;
               end
            end else begin
               state_in = S_LOOK;
            end
         end
         S_UNLOCK: begin
            for (int i = 0; i < MAX_LOCKS; i++) begin
               edges_in[i][idx_ff] = 1'b0;
            end
            edges_in[idx_ff] = '0;
            state_in = S_IDLE;
         end
         // Read the owner of each used slot, add edges, clear self edges.
         S_EDGE: begin
            if (cnt_ff >= used_ff) begin
               state_in = S_SRCH_INIT;
            end else begin
               own_raddr = cnt_idx;
               cnt_in    = cnt_ff + CntW'(1);
               state_in  = S_EDGE_CHK;
            end
         end
         S_EDGE_CHK: begin
            if (tid_ff != '0 && own_rdata == tid_ff) begin
               edges_in[prev_idx][idx_ff] = 1'b1;
            end
            edges_in[prev_idx][prev_idx] = 1'b0;
            state_in = S_EDGE;
         end
         S_SRCH_INIT: begin
            for (int i = 0; i < MAX_LOCKS; i++) begin
               color_in[i] = lodd_pkg::ColorWhite;
               cur_in[i]   = '0;
            end
            depth_in = '0;
            root_in  = '0;
            state_in = S_SRCH;
         end
         // One step of the depth-first search per cycle.
         S_SRCH: begin
            if (depth_ff == '0) begin
               if (root_ff >= used_ff) begin
                  state_in = S_IDLE;
               end else begin
                  if (color_ff[root_ff[IdxW-1:0]] == lodd_pkg::ColorWhite) begin
                     color_in[root_ff[IdxW-1:0]] = lodd_pkg::ColorGrey;
                     stack_in[0] = root_ff[IdxW-1:0];
                     depth_in    = CntW'(1);
                  end
                  root_in = root_ff + CntW'(1);
               end
            end else if (cur_ff[top_n] >= used_ff) begin
               color_in[top_n] = lodd_pkg::ColorBlack;
               depth_in        = depth_ff - CntW'(1);
            end else begin
               cur_in[top_n] = cur_ff[top_n] + CntW'(1);
               if (edges_ff[top_n][cur_j]) begin
                  if (color_ff[cur_j] == lodd_pkg::ColorWhite) begin
                     color_in[cur_j] = lodd_pkg::ColorGrey;
                     if (depth_ff < CntW'(MAX_LOCKS)) begin
                        stack_in[depth_ff[IdxW-1:0]] = cur_j;
                        depth_in = depth_ff + CntW'(1);
                     end
                  end else if (color_ff[cur_j] == lodd_pkg::ColorGrey) begin
                     peak_in  = cur_j;
                     nseen_in = '0;
                     state_in = S_REP;
                  end
               end
            end
         end
         S_REP: begin
            repn_in    = top_n;
            addr_raddr = top_n;
            own_raddr  = top_n;
            depth_in   = depth_ff - CntW'(1);
            state_in   = S_REP_OUT;
         end
         S_REP_OUT: begin
            res_in.valid   = 1'b1;
            res_in.address = addr_rdata;
            res_in.owner   = own_rdata;
            res_in.first   = first_c;
            res_in.status  = lodd_pkg::StatusCycle;
            seen_in[nseen_ff[IdxW-1:0]] = own_rdata;
            nseen_in = nseen_ff + CntW'(1);
            if (repn_ff == peak_ff || depth_ff == '0) begin
               res_in.last = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_REP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         cnt_ff    <= '0;
         used_ff   <= '0;
         depth_ff  <= '0;
         res_ff    <= '0;
         for (int i = 0; i < MAX_LOCKS; i++) begin
            edges_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         used_ff  <= used_in;
         depth_ff <= depth_in;
         res_ff   <= res_in;
         edges_ff <= edges_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      tid_ff   <= tid_in;
      adr_ff   <= adr_in;
      idx_ff   <= idx_in;
      color_ff <= color_in;
      cur_ff   <= cur_in;
      stack_ff <= stack_in;
      root_ff  <= root_in;
      peak_ff  <= peak_in;
      seen_ff  <= seen_in;
      nseen_ff <= nseen_in;
      repn_ff  <= repn_in;
   end

   // The final result lands in the output register as busy falls.
   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = res_ff.valid;
   assign rsp_lock_address_out = res_ff.address;
   assign rsp_owner_thread     = res_ff.owner;
   assign rsp_thread_first     = res_ff.first;
   assign rsp_status           = res_ff.status;
   assign rsp_last             = res_ff.last;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CntW'(MAX_LOCKS)) else $error("slot count overflow");
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CntW'(MAX_LOCKS)) else $error("path depth overflow");
   a_full_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lodd_pkg::StatusFull |-> rsp_last)
      else $error("table-full result without last");
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && !$past(busy) |-> !rsp_valid)
      else $error("result while idle");

endmodule

// ===== tb/sv/lock_order_deadlock_detector_tb.sv =====
module lock_order_deadlock_detector_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NumSlots = lodd_pkg::MaxLocksDefault;
   localparam int unsigned AddrW    = lodd_pkg::AddrWidth;
   localparam int unsigned TidW     = lodd_pkg::TidWidth;

   // Predicts the cycle and table-full reports of the lock-order graph and checks each
   // strobed result against the oldest report still owed by the block.
   class lock_graph_scoreboard;

      typedef struct {
         logic [AddrW-1:0] address;
         logic [TidW-1:0]  owner;
         logic             first;
         logic             status;
         logic             last;
      } report_item_type;

      logic [AddrW-1:0]    slot_address [NumSlots];
      logic [TidW-1:0]     slot_owner [NumSlots];
      logic [NumSlots-1:0] order_row [NumSlots];
      logic [1:0]          color [NumSlots];
      int unsigned         path [NumSlots];
      int unsigned         cursor [NumSlots];
      int unsigned         path_depth;
      int unsigned         used_slots;
      report_item_type     owed_reports [$];
      int unsigned         errors;

      function new();
         used_slots = 0;
         errors     = 0;
         path_depth = 0;
         foreach (slot_owner[i]) begin
            slot_owner[i]   = '0;
            slot_address[i] = '0;
            order_row[i]    = '0;
         end
      endfunction

      // Depth-first search over used slots; returns the grey slot that closes
      // a cycle, or -1. The path is left in place for the report.
      function int find_closing_slot();
         int unsigned n;
         int unsigned j;
         foreach (color[i]) begin
            color[i]  = lodd_pkg::ColorWhite;
            cursor[i] = 0;
         end
         path_depth = 0;
         for (int unsigned s = 0; s < used_slots; s++) begin
            if (color[s] != lodd_pkg::ColorWhite) continue;
            color[s]   = lodd_pkg::ColorGrey;
            cursor[s]  = 0;
            path[0]    = s;
            path_depth = 1;
            while (path_depth > 0) begin
               n = path[path_depth-1];
               if (cursor[n] >= used_slots) begin
                  // A finished node leaves the path.
                  color[n] = lodd_pkg::ColorBlack;
                  path_depth--;
                  continue;
               end
               j = cursor[n];
               cursor[n]++;
               if (!order_row[n][j]) continue;
               if (color[j] == lodd_pkg::ColorWhite) begin
                  color[j]  = lodd_pkg::ColorGrey;
                  cursor[j] = 0;
                  if (path_depth < NumSlots) begin
                     path[path_depth] = j;
                     path_depth++;
                  end
               end else if (color[j] == lodd_pkg::ColorGrey) begin
                  return int'(j);
               end
            end
         end
         return -1;
      endfunction

      // Notes one accepted item and queues the results it must cause.
      function void note_item(logic op, logic [TidW-1:0] tid,
                              logic [AddrW-1:0] addr);
         int unsigned     idx;
         bit              found;
         int              closing;
         int unsigned     n;
         report_item_type entry;
         report_item_type batch [$];
         idx   = 0;
         found = 0;
         for (int unsigned i = 0; i < used_slots; i++) begin
            if (slot_address[i] == addr) begin
               idx   = i;
               found = 1;
               break;
            end
         end
         if (op == lodd_pkg::OpUnlock) begin
            if (found) begin
               slot_owner[idx] = '0;
               order_row[idx]  = '0;
               foreach (order_row[i]) order_row[i][idx] = 1'b0;
            end
            return;
         end
         if (!found) begin
            if (used_slots >= NumSlots) begin
               entry = '{addr, '0, 1'b0, lodd_pkg::StatusFull, 1'b1};
               owed_reports.push_back(entry);
               return;
            end
            idx = used_slots;
            used_slots++;
            slot_address[idx] = addr;
            slot_owner[idx]   = '0;
         end
         if (slot_owner[idx] == '0) slot_owner[idx] = tid;
         for (int unsigned i = 0; i < used_slots; i++) begin
            if (tid != '0 && slot_owner[i] == tid) order_row[i][idx] = 1'b1;
            order_row[i][i] = 1'b0;
         end
         closing = find_closing_slot();
         if (closing < 0) return;
         // Report from the deepest lock back to the closing lock.
         while (path_depth > 0) begin
            path_depth--;
            n = path[path_depth];
            entry = '{slot_address[n], slot_owner[n], 1'b1, lodd_pkg::StatusCycle, 1'b0};
            foreach (batch[p]) if (batch[p].owner == slot_owner[n]) entry.first = 1'b0;
            batch.push_back(entry);
            if (int'(n) == closing) break;
         end
         batch[batch.size()-1].last = 1'b1;
         foreach (batch[p]) owed_reports.push_back(batch[p]);
      endfunction

      function void check_result(logic [AddrW-1:0] addr, logic [TidW-1:0] owner,
                                 logic first, logic status, logic last);
         report_item_type want;
         if (owed_reports.size() == 0) begin
            $display("%0t: result with none expected: addr %h owner %h", $time, addr, owner);
            errors++;
            return;
         end
         want = owed_reports.pop_front();
         if (addr !== want.address) begin
            $display("%0t: lock_address_out expected %h actual %h", $time, want.address, addr);
            errors++;
         end
         if (owner !== want.owner) begin
            $display("%0t: owner_thread expected %h actual %h", $time, want.owner, owner);
            errors++;
         end
         if (first !== want.first) begin
            $display("%0t: thread_first expected %b actual %b", $time, want.first, first);
            errors++;
         end
         if (status !== want.status) begin
            $display("%0t: status expected %b actual %b", $time, want.status, status);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last);
            errors++;
         end
      endfunction

   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_operation = lodd_pkg::OpLock;
   logic [TidW-1:0]  req_thread_id = '0;
   logic [AddrW-1:0] req_lock_address = '0;
   logic             rsp_valid;
   logic [AddrW-1:0] rsp_lock_address_out;
   logic [TidW-1:0]  rsp_owner_thread;
   logic             rsp_thread_first;
   logic             rsp_status;
   logic             rsp_last;

   lock_graph_scoreboard graph_board = new();

   // Address and thread pools are small so that locks are shared, edges pile
   // up and cycles form often. Both address extremes and the largest thread id sit in the pools.
   logic [AddrW-1:0] lock_pool [14];
   logic [TidW-1:0]  thread_pool [5];
   bit               idling_allowed = 1'b1;

   always #4 clock = ~clock;

   lock_order_deadlock_detector DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_thread_id        (req_thread_id),
      .req_lock_address     (req_lock_address),
      .rsp_valid            (rsp_valid),
      .rsp_lock_address_out (rsp_lock_address_out),
      .rsp_owner_thread     (rsp_owner_thread),
      .rsp_thread_first     (rsp_thread_first),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last)
   );

   // Every strobed result must be taken at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         graph_board.check_result(rsp_lock_address_out, rsp_owner_thread,
                                  rsp_thread_first, rsp_status, rsp_last);
      end
   end

   // Presents one item at a falling edge and holds it until a rising edge
   // sees busy low. Start stays high into the next item unless an idle gap
   // is drawn, so back-to-back items never toggle start within one step.
   task automatic send_item(logic op, logic [TidW-1:0] tid,
                            logic [AddrW-1:0] addr);
      int unsigned gap;
      gap = 0;
      if (idling_allowed && $urandom_range(99) < 18) gap = $urandom_range(6, 1);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start            <= 1'b1;
      req_operation    <= op;
      req_thread_id    <= tid;
      req_lock_address <= addr;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      graph_board.note_item(op, tid, addr);
   endtask

   // Mostly pool threads; sometimes no thread, sometimes any thread at all.
   function automatic logic [TidW-1:0] pick_thread();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6) return '0;
      if (roll < 12) return TidW'({$urandom, $urandom});
      return thread_pool[$urandom_range(4)];
   endfunction

   task automatic send_random_item();
      logic [AddrW-1:0] addr;
      logic             op;
      op   = ($urandom_range(99) < 28) ? lodd_pkg::OpUnlock : lodd_pkg::OpLock;
      addr = lock_pool[$urandom_range(13)];
      // An unlock of an address never seen is ignored by the block.
      if (op == lodd_pkg::OpUnlock && $urandom_range(99) < 10) begin
         addr = AddrW'({$urandom, $urandom});
      end
      send_item(op, pick_thread(), addr);
   endtask

   initial begin
      lock_pool[0] = '0;
      lock_pool[1] = '1;
      for (int i = 2; i < 14; i++) lock_pool[i] = AddrW'({$urandom, $urandom});
      thread_pool[0] = 48'd1;
      thread_pool[1] = '1;
      for (int i = 2; i < 5; i++) thread_pool[i] = TidW'({$urandom, $urandom});

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: a two-lock cycle held by one thread, a repeated
      // report while the cycle stands, a lock with no thread, an unlock of
      // an unknown lock, and unlocks that break the cycle again.
      send_item(lodd_pkg::OpLock, thread_pool[0], lock_pool[0]);
      send_item(lodd_pkg::OpLock, thread_pool[0], lock_pool[1]);
      send_item(lodd_pkg::OpLock, thread_pool[1], lock_pool[2]);
      send_item(lodd_pkg::OpLock, thread_pool[1], lock_pool[0]);
      send_item(lodd_pkg::OpLock, thread_pool[0], lock_pool[0]);
      send_item(lodd_pkg::OpLock, '0, lock_pool[1]);
      send_item(lodd_pkg::OpLock, '0, lock_pool[3]);
      send_item(lodd_pkg::OpUnlock, thread_pool[2], AddrW'({$urandom, $urandom}));
      send_item(lodd_pkg::OpUnlock, thread_pool[1], lock_pool[0]);
      send_item(lodd_pkg::OpLock, thread_pool[0], lock_pool[1]);
      send_item(lodd_pkg::OpLock, thread_pool[1], lock_pool[1]);
      send_item(lodd_pkg::OpLock, thread_pool[1], lock_pool[0]);
      send_item(lodd_pkg::OpLock, thread_pool[1], lock_pool[2]);
      send_item(lodd_pkg::OpUnlock, thread_pool[0], lock_pool[1]);
      send_item(lodd_pkg::OpUnlock, '1, lock_pool[0]);

      // Random part over the pool; a stretch in the middle runs with no gaps.
      for (int i = 0; i < 125; i++) begin
         idling_allowed = !(i >= 40 && i < 90);
         send_random_item();
      end

      // New addresses fill the table; later ones must be reported as dropped,
      // while pool locks keep working alongside them.
      for (int i = 0; i < 20; i++) begin
         if (i % 4 == 3) send_random_item();
         else send_item(lodd_pkg::OpLock, pick_thread(), AddrW'({$urandom, $urandom}));
      end

      @(negedge clock);
      start <= 1'b0;

      // Wait for the last results, then some margin for a block that might
      // still emit something unexpected.
      forever begin
         @(posedge clock);
         if (!busy && graph_board.owed_reports.size() == 0) break;
      end
      repeat (600) @(posedge clock);

      if (graph_board.errors == 0 && graph_board.owed_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (graph_board.owed_reports.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     graph_board.owed_reports.size());
         end
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // About 160 items stay far below this bound.
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lodd_pkg.sv
rtl/lodd_table.sv
rtl/lock_order_deadlock_detector.sv
tb/sv/lock_order_deadlock_detector_tb.sv
